@@ rtl/core/sss_pkg.sv @@
// ----------------------------------------------------------------------------
// sss_pkg
// Shared types, constants and the segment decoder of the scrolling
// seven-segment scanner.
// ----------------------------------------------------------------------------
package sss_pkg;

    localparam int DEF_BUFFER_DEPTH = 16;
    localparam int DEF_NUM_CELLS    = 8;

    localparam int CMD_W   = 2;
    localparam int DIGIT_W = 4;
    localparam int CNT_W   = 5;
    localparam int SEG_W   = 8;
    localparam int CODE_W  = 5;

    localparam logic [2:0] CELL_TOP   = 3'd7;
    localparam int         CODE_SHIFT = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE   = 2'd0,
        CMD_SCROLLL = 2'd1,
        CMD_SCROLLR = 2'd2,
        CMD_REFRESH = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd               kind;
        logic               wr_en;
        logic [DIGIT_W-1:0] index;
        logic [DIGIT_W-1:0] value;
    } t_op;

    function automatic logic [SEG_W-1:0] seg_decode(input logic [DIGIT_W-1:0] code);
        logic [SEG_W-1:0] seg;
        unique case (code)
            4'd0:    seg = 8'h3F;
            4'd1:    seg = 8'h06;
            4'd2:    seg = 8'h5B;
            4'd3:    seg = 8'h4F;
            4'd4:    seg = 8'h66;
            4'd5:    seg = 8'h6D;
            4'd6:    seg = 8'h7D;
            4'd7:    seg = 8'h07;
            4'd8:    seg = 8'h7F;
            4'd9:    seg = 8'h6F;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

endpackage

@@ rtl/core/sss_front.sv @@
// ----------------------------------------------------------------------------
// sss_front
// Input stage: accepts commands, classifies them and pushes them to the queue.
// ----------------------------------------------------------------------------
module sss_front import sss_pkg::*; #(
    parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [CMD_W-1:0]   i_cmd,
    input  logic [DIGIT_W-1:0] i_digit_index,
    input  logic [DIGIT_W-1:0] i_digit_value,
    output logic               o_push_valid,
    input  logic               i_push_ready,
    output t_op                o_push_op
);

    localparam logic [8:0] DEPTH9 = 9'(BUFFER_DEPTH);

    logic r_vld;
    logic n_vld;
    t_op  r_op;
    t_op  n_op;
    logic accept;

    assign o_ready      = !r_vld || i_push_ready;
    assign accept       = i_valid && o_ready;
    assign o_push_valid = r_vld;
    assign o_push_op    = r_op;

    always_comb begin
        n_op       = r_op;
        n_vld      = r_vld;
        if (accept) begin
            n_op.kind  = t_cmd'(i_cmd);
            n_op.wr_en = (t_cmd'(i_cmd) == CMD_WRITE) && ({5'd0, i_digit_index} < DEPTH9);
            n_op.index = i_digit_index;
            n_op.value = i_digit_value;
            n_vld      = 1'b1;
        end else if (i_push_ready) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op;
    end

endmodule

@@ rtl/core/sss_queue.sv @@
// ----------------------------------------------------------------------------
// sss_queue
// Two-entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
module sss_queue import sss_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_op  i_push_op,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_op  o_pop_op
);

    t_op        r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_pop_op     = r_mem[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push_op;
        end
    end

endmodule

@@ rtl/core/sss_back.sv @@
// ----------------------------------------------------------------------------
// sss_back
// Execution part: digit buffer, scroll offset, cell sequencer and output stage.
// ----------------------------------------------------------------------------
module sss_back import sss_pkg::*; #(
    parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH,
    parameter int NUM_CELLS    = DEF_NUM_CELLS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CNT_W-1:0]   i_cfg_wdata,
    input  logic               i_op_valid,
    output logic               o_op_ready,
    input  t_op                i_op,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [SEG_W-1:0]   o_segments,
    output logic [CODE_W-1:0]  o_cell_code,
    output logic               o_last
);

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CW = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam logic [8:0]    DEPTH9    = 9'(BUFFER_DEPTH);
    localparam logic [CW-1:0] CELL_LAST = CW'(NUM_CELLS - 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_offset, n_offset;
    logic [CNT_W-1:0]   r_pos, n_pos;
    logic [CW-1:0]      r_cell, n_cell;
    logic [DIGIT_W-1:0] r_mem [BUFFER_DEPTH];
    logic [DIGIT_W-1:0] r_mem_q;
    logic [CW-1:0]      r_rd_cell;
    logic               r_rd_vld, n_rd_vld;
    logic               r_out_vld;
    logic [SEG_W-1:0]   r_out_seg;
    logic [CODE_W-1:0]  r_out_code;
    logic               r_out_last;

    logic             scan;
    logic             out_free;
    logic             move;
    logic             issue;
    logic             cell_end;
    logic             pop;
    logic [CNT_W-1:0] pos_inc;
    logic [CNT_W-1:0] ofs_inc;
    logic [CNT_W-1:0] cfg_count;

    assign scan     = (r_state == ST_SCAN);
    assign out_free = !r_out_vld || i_ready;
    assign move     = r_rd_vld && out_free;
    assign issue    = scan && (!r_rd_vld || out_free);
    assign cell_end = (r_cell == CELL_LAST);
    assign pop      = i_op_valid && (!scan || (issue && cell_end));
    assign pos_inc  = r_pos + 1'b1;
    assign ofs_inc  = r_offset + 1'b1;

    assign o_op_ready  = !scan || (issue && cell_end);
    assign o_valid     = r_out_vld;
    assign o_segments  = r_out_seg;
    assign o_cell_code = r_out_code;
    assign o_last      = r_out_last;

    // clamp count to 1..BUFFER_DEPTH
    always_comb begin
        if (i_cfg_wdata == '0) begin
            cfg_count = CNT_W'(1);
        end else if ({4'd0, i_cfg_wdata} > DEPTH9) begin
            cfg_count = DEPTH9[CNT_W-1:0];
        end else begin
            cfg_count = i_cfg_wdata;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_pos    = r_pos;
        n_cell   = r_cell;
        n_offset = r_offset;
        if (issue) begin
            n_pos  = (pos_inc == r_count) ? '0 : pos_inc;
            n_cell = CW'(r_cell + 1'b1);
            if (cell_end) begin
                n_state = ST_IDLE;
            end
        end
        if (pop) begin
            case (i_op.kind)
                CMD_SCROLLL: n_offset = (ofs_inc == r_count) ? '0 : ofs_inc;
                CMD_SCROLLR: n_offset = (r_offset == '0) ? r_count - 1'b1 : r_offset - 1'b1;
                CMD_REFRESH: begin
                    n_state = ST_SCAN;
                    n_pos   = r_offset;
                    n_cell  = '0;
                end
                default: ;
            endcase
        end
        n_rd_vld = issue ? 1'b1 : (move ? 1'b0 : r_rd_vld);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= CNT_W'(1);
            r_offset  <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= n_rd_vld;
            if (i_cfg_we) begin
                r_count  <= cfg_count;
                r_offset <= '0;
            end else begin
                r_offset <= n_offset;
            end
            if (move) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_cell <= n_cell;
        if (pop && i_op.kind == CMD_WRITE && i_op.wr_en) begin
            r_mem[AW'(i_op.index)] <= i_op.value;
        end
        if (issue) begin
            r_mem_q   <= r_mem[AW'(r_pos)];
            r_rd_cell <= r_cell;
        end
        if (move) begin
            r_out_seg  <= seg_decode(r_mem_q);
            r_out_code <= CODE_W'(CELL_TOP - 3'(r_rd_cell)) << CODE_SHIFT;
            r_out_last <= (r_rd_cell == CELL_LAST);
        end
    end

endmodule

@@ rtl/core/scrolling_seven_segment_scanner_core.sv @@
// ----------------------------------------------------------------------------
// scrolling_seven_segment_scanner_core
// Scrolling digit buffer driving multiplexed seven-segment cells.
//
// Commands enter on i_valid/o_ready with i_cmd, i_digit_index and
// i_digit_value: write digit, scroll left, scroll right, refresh.
// A refresh produces NUM_CELLS transfers on o_valid/i_ready, cell 0 first,
// each with the segment pattern, the cell select code and o_last on the
// final one. Write and scroll produce no transfer.
// The digit count is written through i_cfg_we/i_cfg_wdata and clears the
// scroll offset; the user must write it only while idle (not enforced).
// A refresh steps through NUM_CELLS cells, one cell per cycle while the
// receiver is ready, through the single read port of the digit buffer;
// each cell passes a read register and then the output register. Write
// and scroll are done in the back part as they leave the queue.
// A stalled receiver holds the output register and the cell sequencer;
// commands keep entering until the two-entry queue and input stage fill.
// Reset clears the offset, sets the count to one and empties the queue;
// buffer contents are undefined until written.
// ----------------------------------------------------------------------------
module scrolling_seven_segment_scanner_core import sss_pkg::*; #(
    parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH,
    parameter int NUM_CELLS    = DEF_NUM_CELLS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CNT_W-1:0]   i_cfg_wdata,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [CMD_W-1:0]   i_cmd,
    input  logic [DIGIT_W-1:0] i_digit_index,
    input  logic [DIGIT_W-1:0] i_digit_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [SEG_W-1:0]   o_segments,
    output logic [CODE_W-1:0]  o_cell_code,
    output logic               o_last
);

    logic push_valid;
    logic push_ready;
    t_op  push_op;
    logic op_valid;
    logic op_ready;
    t_op  op;

    sss_front #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_cmd         (i_cmd),
        .i_digit_index (i_digit_index),
        .i_digit_value (i_digit_value),
        .o_push_valid  (push_valid),
        .i_push_ready  (push_ready),
        .o_push_op     (push_op)
    );

    sss_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_op    (push_op),
        .o_pop_valid  (op_valid),
        .i_pop_ready  (op_ready),
        .o_pop_op     (op)
    );

    sss_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .NUM_CELLS    (NUM_CELLS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_op_valid  (op_valid),
        .o_op_ready  (op_ready),
        .i_op        (op),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_segments  (o_segments),
        .o_cell_code (o_cell_code),
        .o_last      (o_last)
    );

endmodule
